@@ design/dnsq_pkg.sv @@
// shared types and constants for the dns query name parser
package dnsq_pkg;

    // packet geometry
    localparam int MAX_PACKET_BYTES = 4096;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int HDR_BYTES        = 12;
    localparam int QEND_W           = 13;

    // output queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // protocol constants
    localparam logic [7:0] PTR_MASK = 8'hC0;
    localparam logic [7:0] DOT_CHAR = 8'h2E;

    // result kinds
    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // parse status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_POINTER  = 3'd2,
        ST_OVERRUN  = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    // one result beat
    typedef struct packed {
        logic              result_kind;
        logic [7:0]        name_char;
        status_t           parse_status;
        logic [QEND_W-1:0] question_end;
        logic [15:0]       query_id;
        logic [15:0]       query_type;
        logic              end_of_run;
    } result_t;

endpackage

@@ design/dnsq_parser.sv @@
// byte-wide parser core: header, label walk and qtype capture
module dnsq_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              beat,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output dnsq_pkg::result_t res0,
    output dnsq_pkg::result_t res1,
    output logic [1:0]        res_count
);
    import dnsq_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_LABEL,
        PH_TYPE_HI,
        PH_TYPE_LO,
        PH_DONE,
        PH_ERROR
    } phase_t;

    logic [POS_W-1:0]  pos_reg,     pos_next;
    phase_t            phase_reg,   phase_next;
    logic [5:0]        remain_reg,  remain_next;
    logic              started_reg, started_next;
    logic [15:0]       id_reg,      id_next;
    logic [15:0]       type_reg,    type_next;
    status_t           err_reg,     err_next;
    logic [QEND_W-1:0] end_reg,     end_next;

    logic              char_valid;
    logic [7:0]        char_val;
    status_t           sum_status;
    result_t           char_res;
    result_t           sum_res;

    // next state for one byte
    always_comb
    begin
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        remain_next  = remain_reg;
        started_next = started_reg;
        id_next      = id_reg;
        type_next    = type_reg;
        err_next     = err_reg;
        end_next     = end_reg;
        char_valid   = 1'b0;
        char_val     = 8'h00;
        if (pos_reg < POS_W'(MAX_PACKET_BYTES))
        begin
            pos_next = pos_reg + POS_W'(1);
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg == POS_W'(0))
                        id_next = {data_byte, 8'h00};
                    else if (pos_reg == POS_W'(1))
                        id_next = {id_reg[15:8], data_byte};
                    if (pos_reg >= POS_W'(HDR_BYTES - 1))
                        phase_next = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    if (data_byte == 8'h00)
                    begin
                        end_next   = QEND_W'(pos_reg + POS_W'(5));
                        phase_next = PH_TYPE_HI;
                    end
                    else if ((data_byte & PTR_MASK) != 8'h00)
                    begin
                        err_next   = ST_POINTER;
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        if (started_reg)
                        begin
                            char_valid = 1'b1;
                            char_val   = DOT_CHAR;
                        end
                        started_next = 1'b1;
                        remain_next  = data_byte[5:0];
                        phase_next   = PH_LABEL;
                    end
                end
                PH_LABEL:
                begin
                    char_valid  = 1'b1;
                    char_val    = data_byte;
                    remain_next = remain_reg - 6'd1;
                    if (remain_next == 6'd0)
                        phase_next = PH_LENGTH;
                end
                PH_TYPE_HI:
                begin
                    type_next  = {data_byte, 8'h00};
                    phase_next = PH_TYPE_LO;
                end
                PH_TYPE_LO:
                begin
                    type_next  = {type_reg[15:8], data_byte};
                    phase_next = PH_DONE;
                end
                PH_DONE, PH_ERROR:
                begin
                end
                default:
                begin
                end
            endcase
        end

        // summary status from the updated state
        priority if (err_next != ST_OK)
            sum_status = err_next;
        else if (pos_next <= POS_W'(HDR_BYTES))
            sum_status = ST_SHORT;
        else if (phase_next == PH_LENGTH || phase_next == PH_LABEL)
            sum_status = ST_OVERRUN;
        else if (!started_next)
            sum_status = ST_EMPTY;
        else
            sum_status = ST_OK;

        sum_res.result_kind  = KIND_SUMMARY;
        sum_res.name_char    = 8'h00;
        sum_res.parse_status = sum_status;
        sum_res.question_end = end_next;
        sum_res.query_id     = id_next;
        sum_res.query_type   = (phase_next == PH_DONE) ? type_next : 16'h0000;
        sum_res.end_of_run   = 1'b1;

        char_res.result_kind  = KIND_CHAR;
        char_res.name_char    = char_val;
        char_res.parse_status = ST_OK;
        char_res.question_end = '0;
        char_res.query_id     = 16'h0000;
        char_res.query_type   = 16'h0000;
        char_res.end_of_run   = 1'b0;

        // back to the start of a packet after its last byte
        if (last_byte)
        begin
            pos_next     = '0;
            phase_next   = PH_HEADER;
            remain_next  = 6'd0;
            started_next = 1'b0;
            id_next      = 16'h0000;
            type_next    = 16'h0000;
            err_next     = ST_OK;
            end_next     = '0;
        end
    end

    // results of this beat, character first
    assign res0      = char_valid ? char_res : sum_res;
    assign res1      = sum_res;
    assign res_count = {1'b0, char_valid} + {1'b0, last_byte};

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            phase_reg   <= PH_HEADER;
            remain_reg  <= 6'd0;
            started_reg <= 1'b0;
            id_reg      <= 16'h0000;
            type_reg    <= 16'h0000;
            err_reg     <= ST_OK;
            end_reg     <= '0;
        end
        else if (beat)
        begin
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            remain_reg  <= remain_next;
            started_reg <= started_next;
            id_reg      <= id_next;
            type_reg    <= type_next;
            err_reg     <= err_next;
            end_reg     <= end_next;
        end
    end

endmodule

@@ design/dns_query_name_parser_unit.sv @@
// top level: dns query name parser with output result queue
//
// Input stream carries one packet byte per beat (tdata) with tlast on the
// final byte of the packet. The output stream carries name characters
// (tuser 0, a dot before every label after the first) and, after the last
// byte of a packet, one summary beat (tuser 1, tlast 1) with status,
// question end offset, transaction id and qtype.
// Each result is written into the result queue on its input beat and is
// offered from the queue head. Throughput: one input byte per cycle while
// s_tready is high; a byte that yields both a character and the summary
// takes two output beats, and the four-entry result queue absorbs the extra beat.
// s_tready is high while the queue has room for two results, so input
// keeps flowing while a result waits to be taken. When the receiver
// stalls, s_tready drops once three results wait in the queue; header
// bytes give no result and keep flowing until then.
// Reset empties the queue and returns the parser to the start of a packet.
// After a summary the parser is ready for the next packet at once.
// Status other than ok means the receiver is to drop the characters of that
// packet; the block itself does not drop them.
module dns_query_name_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // name_char[7:0], parse_status[10:8],
                                   // question_end[23:11], query_id[39:24],
                                   // query_type[55:40]
    output logic [0:0]  m_tuser,   // result_kind[0]
    output logic        m_tlast
);
    import dnsq_pkg::*;

    logic              in_beat;
    logic              out_beat;
    result_t           res0;
    result_t           res1;
    logic [1:0]        res_count;
    logic [1:0]        push_n;
    result_t           fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    result_t           head;

    assign s_tready = count_reg <= CNT_W'(FIFO_DEPTH - 2);
    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // parser core
    dnsq_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (in_beat),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    assign push_n = in_beat ? res_count : 2'd0;

    // queue pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = out_beat ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(out_beat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            fifo_reg[wr_ptr_reg] <= res0;
        if (push_n == 2'd2)
            fifo_reg[wr_ptr_reg + PTR_W'(1)] <= res1;
    end

    // output beat from queue head
    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tvalid = count_reg != '0;
    assign m_tdata  = {head.query_type, head.query_id, head.question_end,
                       head.parse_status, head.name_char};
    assign m_tuser  = head.result_kind;
    assign m_tlast  = head.end_of_run;

    // queue never overfills
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    // an ok summary always follows a seen terminator
    a_ok_has_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && head.result_kind == KIND_SUMMARY && head.parse_status == ST_OK)
        |-> (head.question_end >= QEND_W'(HDR_BYTES + 6)))
        else $error("ok summary without terminator offset");

    // a character beat never closes a run
    a_char_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && head.result_kind == KIND_CHAR)
        |-> (!head.end_of_run && head.parse_status == ST_OK))
        else $error("character beat marked as summary");

endmodule

@@ tb/sv/tb_top.sv @@
// testbench for the dns query name parser: directed and random packets checked beat by beat
`timescale 1ns / 1ps

module tb_top;
    import dnsq_pkg::*;

    // parser phases of the predictor
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_LABEL,
        PH_TYPE_HI,
        PH_TYPE_LO,
        PH_DONE,
        PH_ERROR
    } parse_phase_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // data_byte[7:0]
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;            // name_char[7:0], parse_status[10:8],
                                     // question_end[23:11], query_id[39:24],
                                     // query_type[55:40]
    logic [0:0]  m_tuser;            // result_kind[0]
    logic        m_tlast;

    // predictor state for the packet in flight
    int unsigned    byte_pos;
    parse_phase_t   phase;
    logic [5:0]     label_left;
    bit             name_seen;
    logic [15:0]    id_reg;
    logic [15:0]    qtype_reg;
    status_t        err_status;
    logic [12:0]    qend_reg;

    // parsed results still to come out of the block
    result_t        parsed_results[$];

    // packet under construction
    logic [7:0]     pkt[$];

    int unsigned    mismatch_count = 0;
    int unsigned    beat_count     = 0;
    int unsigned    bytes_sent     = 0;
    int unsigned    send_idle_pct  = 0;
    int unsigned    recv_idle_pct  = 0;
    int unsigned    hold_cycles    = 0;
    int unsigned    held_count     = 0;

    dns_query_name_parser_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic log_mismatch(input string msg);
        if (mismatch_count < 40)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic clear_parse_state();
        byte_pos   = 0;
        phase      = PH_HEADER;
        label_left = '0;
        name_seen  = 1'b0;
        id_reg     = '0;
        qtype_reg  = '0;
        err_status = ST_OK;
        qend_reg   = '0;
    endtask

    task automatic push_name_char(input logic [7:0] c);
        result_t r;
        r             = '0;
        r.result_kind = KIND_CHAR;
        r.name_char   = c;
        parsed_results.push_back(r);
    endtask

    // predict the results of one accepted byte
    task automatic parse_byte(input logic [7:0] b, input logic last);
        result_t     r;
        int unsigned p;
        if (byte_pos < MAX_PACKET_BYTES)
        begin
            p        = byte_pos;
            byte_pos = p + 1;
            case (phase)
                PH_HEADER:
                begin
                    if (p == 0)
                        id_reg = {b, 8'h00};
                    else if (p == 1)
                        id_reg[7:0] = b;
                    if (p + 1 >= HDR_BYTES)
                        phase = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    if (b == 8'h00)
                    begin
                        qend_reg = QEND_W'(p + 5);
                        phase    = PH_TYPE_HI;
                    end
                    else if ((b & PTR_MASK) != 8'h00)
                    begin
                        err_status = ST_POINTER;
                        phase      = PH_ERROR;
                    end
                    else
                    begin
                        if (name_seen)
                            push_name_char(DOT_CHAR);
                        name_seen  = 1'b1;
                        label_left = b[5:0];
                        phase      = PH_LABEL;
                    end
                end
                PH_LABEL:
                begin
                    push_name_char(b);
                    label_left = label_left - 6'd1;
                    if (label_left == 6'd0)
                        phase = PH_LENGTH;
                end
                PH_TYPE_HI:
                begin
                    qtype_reg = {b, 8'h00};
                    phase     = PH_TYPE_LO;
                end
                PH_TYPE_LO:
                begin
                    qtype_reg[7:0] = b;
                    phase          = PH_DONE;
                end
                default:
                begin
                end
            endcase
        end

        // summary beat closes the packet
        if (last)
        begin
            r             = '0;
            r.result_kind = KIND_SUMMARY;
            if (err_status != ST_OK)
                r.parse_status = err_status;
            else if (byte_pos <= HDR_BYTES)
                r.parse_status = ST_SHORT;
            else if (phase == PH_LENGTH || phase == PH_LABEL)
                r.parse_status = ST_OVERRUN;
            else if (!name_seen)
                r.parse_status = ST_EMPTY;
            else
                r.parse_status = ST_OK;
            r.question_end = qend_reg;
            r.query_id     = id_reg;
            r.query_type   = (phase == PH_DONE) ? qtype_reg : 16'h0000;
            r.end_of_run   = 1'b1;
            parsed_results.push_back(r);
            clear_parse_state();
        end
    endtask

    // offer one byte and wait for the handshake
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        parse_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    task automatic push_header(input logic [15:0] id);
        pkt.push_back(id[15:8]);
        pkt.push_back(id[7:0]);
        repeat (HDR_BYTES - 2)
            pkt.push_back(8'($urandom));
    endtask

    task automatic push_label(input int unsigned len);
        pkt.push_back(8'(len));
        repeat (len)
            pkt.push_back(8'($urandom));
    endtask

    // receiver: random stalls, or a long hold counted here once requested
    always @(posedge clk)
    begin
        if (held_count < hold_cycles)
        begin
            m_tready   <= 1'b0;
            held_count <= held_count + 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic check_field(input string fname, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            log_mismatch($sformatf("beat %0d %s: got 0x%0h want 0x%0h",
                                   beat_count, fname, got, want));
    endtask

    // compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            if (parsed_results.size() == 0)
                log_mismatch($sformatf("beat %0d arrived with nothing pending", beat_count));
            else
            begin
                want = parsed_results.pop_front();
                check_field("result_kind", 16'(m_tuser[0]), 16'(want.result_kind));
                check_field("name_char", 16'(m_tdata[7:0]), 16'(want.name_char));
                check_field("parse_status", 16'(m_tdata[10:8]), 16'(want.parse_status));
                check_field("question_end", 16'(m_tdata[23:11]), 16'(want.question_end));
                check_field("query_id", m_tdata[39:24], want.query_id);
                check_field("query_type", m_tdata[55:40], want.query_type);
                check_field("end_of_run", 16'(m_tlast), 16'(want.end_of_run));
            end
            beat_count++;
        end
    end

    // packets of at most twelve bytes
    task automatic test_short_packets();
        pkt = {8'hFF};
        send_packet();
        pkt = {8'h00, 8'hFF};
        send_packet();
        pkt.delete();
        push_header(16'hFFFF);
        send_packet();
    endtask

    // zero byte right after the header
    task automatic test_empty_name();
        pkt.delete();
        push_header(16'h0000);
        pkt.push_back(8'h00);
        pkt.push_back(8'hFF);
        pkt.push_back(8'hFF);
        pkt.push_back(8'h00);
        pkt.push_back(8'h01);
        send_packet();
    endtask

    // compression and reserved length bits, first and later label
    task automatic test_pointer_bits();
        logic [7:0] marks[3];
        marks = '{8'hC0, 8'h40, 8'h80};
        foreach (marks[i])
        begin
            pkt.delete();
            push_header(16'(i * 16'h1111));
            pkt.push_back(marks[i]);
            pkt.push_back(8'h00);
            pkt.push_back(8'h05);
            send_packet();
        end
        pkt.delete();
        push_header(16'hABCD);
        push_label(3);
        pkt.push_back(8'hFF);
        push_label(2);
        pkt.push_back(8'h00);
        send_packet();
    endtask

    // packet ends inside a label, then right after one
    task automatic test_label_overrun();
        pkt.delete();
        push_header(16'h1234);
        push_label(5);
        void'(pkt.pop_back());
        send_packet();
        pkt.delete();
        push_header(16'h4321);
        push_label(4);
        send_packet();
    endtask

    // qtype missing, cut short, or complete
    task automatic test_question_tail();
        pkt.delete();
        push_header(16'h0102);
        push_label(1);
        pkt.push_back(8'h00);
        send_packet();
        pkt.delete();
        push_header(16'h0304);
        push_label(2);
        pkt.push_back(8'h00);
        pkt.push_back(8'hFF);
        send_packet();
        pkt.delete();
        push_header(16'h0506);
        push_label(2);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        send_packet();
    endtask

    // longest label, extreme characters and qtype
    task automatic test_max_label();
        pkt.delete();
        push_header(16'hFFFF);
        pkt.push_back(8'd63);
        for (int i = 0; i < 63; i++)
            pkt.push_back((i % 2 == 0) ? 8'h00 : 8'hFF);
        push_label(1);
        pkt.push_back(8'h00);
        pkt.push_back(8'hFF);
        pkt.push_back(8'hFF);
        pkt.push_back(8'h00);
        pkt.push_back(8'h01);
        send_packet();
    endtask

    task automatic make_random_packet();
        int unsigned kind;
        int unsigned n_labels;
        int unsigned keep;
        kind = $urandom_range(99);
        pkt.delete();
        if (kind >= 94)
        begin
            // pure noise
            repeat ($urandom_range(1, 30))
                pkt.push_back(8'($urandom));
            return;
        end
        push_header(16'($urandom));
        if (kind >= 88)
            n_labels = 0;
        else
            n_labels = $urandom_range(1, 4);
        repeat (n_labels)
            push_label(($urandom_range(9) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 8));
        // terminator, or a pointer in its place
        if (kind >= 80 && kind < 88)
            pkt.push_back(8'($urandom_range(64, 255)));
        else
            pkt.push_back(8'h00);
        repeat (4)
            pkt.push_back(8'($urandom));
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 6))
                pkt.push_back(8'($urandom));
        // truncated packet
        if (kind >= 70 && kind < 80)
        begin
            keep = $urandom_range(1, pkt.size());
            while (pkt.size() > keep)
                void'(pkt.pop_back());
        end
    endtask

    task automatic test_random_packets(input int unsigned budget);
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            make_random_packet();
            send_packet();
        end
    endtask

    // long receiver hold while the sender keeps offering
    task automatic test_backpressure();
        int unsigned saved_pct;
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        hold_cycles   = held_count + 150;
        pkt.delete();
        push_header(16'hBEEF);
        repeat (5)
            push_label(10);
        pkt.push_back(8'h00);
        repeat (4)
            pkt.push_back(8'($urandom));
        send_packet();
        send_idle_pct = saved_pct;
    endtask

    // name up to the last counted position, trailing bytes past the limit
    task automatic test_oversize_packet();
        pkt.delete();
        push_header(16'h5A5A);
        repeat (63)
            push_label(63);
        push_label(50);
        pkt.push_back(8'h00);
        pkt.push_back(8'h12);
        pkt.push_back(8'h34);
        pkt.push_back(8'h56);
        pkt.push_back(8'h78);
        send_packet();
    endtask

    initial
    begin
        clear_parse_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 17;
        recv_idle_pct = 46;
        test_short_packets();
        test_empty_name();
        test_pointer_bits();
        test_label_overrun();
        test_question_tail();
        test_max_label();
        test_random_packets(600);

        send_idle_pct = 46;
        recv_idle_pct = 17;
        test_random_packets(600);
        test_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_packets(600);
        test_oversize_packet();
        s_tvalid <= 1'b0;

        // drain what is still pending
        for (int w = 0; w < 50000 && parsed_results.size() != 0; w++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (parsed_results.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", parsed_results.size()));

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
